// ===== src/gga_pkg.sv =====
// ----------------------------------------------------------------------------
// gga_pkg: shared types and constants of the GGA sentence parser
// Character codes, record slot map, clamp ranges and feet scaling constants.
// ----------------------------------------------------------------------------
package gga_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_F      = 8'h46;

    localparam logic [7:0] HDR_TEXT [0:4] = '{8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
    localparam logic [2:0] HDR_LEN = 3'd5;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_CKSUM   = 2'd2
    } t_status;

    localparam int NSLOT  = 9;
    localparam int SLOT_W = 36;

    localparam logic [3:0] SL_TIME = 4'd0;
    localparam logic [3:0] SL_LAT  = 4'd1;
    localparam logic [3:0] SL_LON  = 4'd2;
    localparam logic [3:0] SL_QUAL = 4'd3;
    localparam logic [3:0] SL_HDOP = 4'd4;
    localparam logic [3:0] SL_ALT  = 4'd5;
    localparam logic [3:0] SL_GEO  = 4'd6;
    localparam logic [3:0] SL_AGE  = 4'd7;
    localparam logic [3:0] SL_STA  = 4'd8;
    localparam logic [3:0] NO_SLOT = 4'hF;

    // field number -> record slot
    localparam logic [3:0] SLOT_OF_FIELD [0:15] = '{
        NO_SLOT, SL_TIME, SL_LAT, NO_SLOT, SL_LON, NO_SLOT, SL_QUAL, NO_SLOT,
        SL_HDOP, SL_ALT, NO_SLOT, SL_GEO, NO_SLOT, SL_AGE, SL_STA, NO_SLOT};

    // unit and hemisphere fields
    localparam logic [3:0] FN_NS      = 4'd3;
    localparam logic [3:0] FN_EW      = 4'd5;
    localparam logic [3:0] FN_ALT_U   = 4'd10;
    localparam logic [3:0] FN_GEO_U   = 4'd12;
    localparam logic [3:0] FN_LAST    = 4'd15;

    localparam logic signed [63:0] SLOT_LO [0:8] = '{
        64'sd0, -64'sd90000000, -64'sd180000000, 64'sd0, 64'sd0,
        -64'sd34359738368, -64'sd34359738368, 64'sd0, 64'sd0};
    localparam logic signed [63:0] SLOT_HI [0:8] = '{
        64'sd2359599999, 64'sd90000000, 64'sd180000000, 64'sd4, 64'sd9999999,
        64'sd34359738367, 64'sd34359738367, 64'sd99999999, 64'sd1023};

    localparam logic [63:0] POW10 [0:6] = '{
        64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000};

    // feet scaling: floor((m * 328084 + 50000) / 100000), division by 100000
    // done as a shift by 5 and a reciprocal multiply for 3125
    localparam logic [63:0] FEET_NUM  = 64'd328084;
    localparam logic [63:0] FEET_DEN  = 64'd100000;
    localparam logic [63:0] FEET_HALF = 64'd50000;
    localparam logic [63:0] FEET_M1   = 64'd703687442;   // ceil(2^41 / 3125)
    localparam int          FEET_K1   = 41;
    localparam logic [63:0] FEET_M2   = 64'd1407374884;  // ceil(2^42 / 3125)
    localparam int          FEET_K2   = 42;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef t_slot [NSLOT-1:0] t_rec;

    typedef struct packed {
        logic neg_lat;
        logic neg_lon;
        logic feet_alt;
        logic feet_geo;
    } t_units;

    typedef struct packed {
        logic       valid;
        logic       commit;
        logic [3:0] slot;
        logic [2:0] fd;
        logic       neg;
        logic       emit;
        t_status    status;
        logic       clear;
        t_units     units;
    } t_op;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

// ===== src/gga_parse.sv =====
// ----------------------------------------------------------------------------
// gga_parse: per-byte sentence parser
// Tracks header, fields, checksum and number accumulation; issues field commit,
// record clear and record emit operations into a one-deep operation register.
// ----------------------------------------------------------------------------
module gga_parse #(
    parameter int VALUE_BITS      = 36,
    parameter int FRACTION_DIGITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    output logic                  o_ready,
    output gga_pkg::t_op          o_op,
    output logic [VALUE_BITS-1:0] o_mag,
    input  logic                  i_take
);

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_FIELDS = 5'b00100,
        PH_CHECK  = 5'b01000,
        PH_SKIP   = 5'b10000
    } t_phase;

    localparam logic [VALUE_BITS-1:0] MAX_MAG = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [2:0]            FD_MAX  = 3'(FRACTION_DIGITS);

    t_phase                r_phase, n_phase;
    logic [2:0]            r_hm, n_hm;
    logic [3:0]            r_field, n_field;
    logic [7:0]            r_xor, n_xor;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [2:0]            r_fd, n_fd;
    logic                  r_neg, n_neg;
    logic                  r_point, n_point;
    logic [7:0]            r_rx, n_rx;
    gga_pkg::t_units       r_units, n_units;
    gga_pkg::t_op          r_op, n_op;
    logic [VALUE_BITS-1:0] r_mag, n_mag;

    logic                  adv;
    logic [VALUE_BITS+3:0] push_w;
    logic [VALUE_BITS-1:0] pushed;
    logic [3:0]            cur_slot;
    logic                  is_digit;
    gga_pkg::t_op          op_new;
    logic                  op_fire;

    assign o_ready = !r_op.valid || i_take;
    assign adv     = i_valid && o_ready;
    assign o_op    = r_op;
    assign o_mag   = r_mag;

    assign cur_slot = gga_pkg::SLOT_OF_FIELD[r_field];
    assign is_digit = (i_byte >= gga_pkg::CH_ZERO) && (i_byte <= gga_pkg::CH_NINE);
    assign push_w   = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                    + (VALUE_BITS+4)'(i_byte[3:0]);
    assign pushed   = (push_w > (VALUE_BITS+4)'(MAX_MAG)) ? MAX_MAG
                                                          : push_w[VALUE_BITS-1:0];

    always_comb begin
        n_phase = r_phase;
        n_hm    = r_hm;
        n_field = r_field;
        n_xor   = r_xor;
        n_acc   = r_acc;
        n_fd    = r_fd;
        n_neg   = r_neg;
        n_point = r_point;
        n_rx    = r_rx;
        n_units = r_units;
        n_op    = r_op;
        n_mag   = r_mag;
        op_fire = 1'b0;
        op_new  = '0;
        op_new.valid  = 1'b1;
        op_new.slot   = cur_slot;
        op_new.fd     = r_fd;
        op_new.neg    = r_neg;
        op_new.units  = r_units;
        op_new.status = gga_pkg::ST_VALID;

        if (i_take) begin
            n_op.valid = 1'b0;
        end

        if (adv) begin
            if (i_byte == gga_pkg::CH_DOLLAR) begin
                op_fire      = 1'b1;
                op_new.clear = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if (i_byte == gga_pkg::CH_CR) begin
                            op_fire       = 1'b1;
                            op_new.emit   = 1'b1;
                            op_new.status = gga_pkg::ST_UNKNOWN;
                        end else begin
                            n_xor = r_xor ^ i_byte;
                            if (r_hm != gga_pkg::HDR_LEN) begin
                                if (i_byte == gga_pkg::HDR_TEXT[r_hm]) begin
                                    n_hm = r_hm + 3'd1;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end else if (i_byte == gga_pkg::CH_COMMA) begin
                                n_phase = PH_FIELDS;
                                n_field = 4'd1;
                                n_acc   = '0;
                                n_fd    = 3'd0;
                                n_neg   = 1'b0;
                                n_point = 1'b0;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP: begin
                        if (i_byte == gga_pkg::CH_CR) begin
                            op_fire       = 1'b1;
                            op_new.emit   = 1'b1;
                            op_new.status = gga_pkg::ST_UNKNOWN;
                        end
                    end
                    PH_FIELDS: begin
                        if (i_byte == gga_pkg::CH_CR) begin
                            op_fire       = 1'b1;
                            op_new.commit = (cur_slot != gga_pkg::NO_SLOT);
                            op_new.emit   = 1'b1;
                            op_new.status = gga_pkg::ST_CKSUM;
                        end else if (i_byte == gga_pkg::CH_STAR) begin
                            op_fire       = 1'b1;
                            op_new.commit = (cur_slot != gga_pkg::NO_SLOT);
                            n_phase       = PH_CHECK;
                            n_fd          = 3'd0;
                            n_rx          = 8'd0;
                        end else begin
                            n_xor = r_xor ^ i_byte;
                            if (i_byte == gga_pkg::CH_COMMA) begin
                                op_fire       = 1'b1;
                                op_new.commit = (cur_slot != gga_pkg::NO_SLOT);
                                if (r_field != gga_pkg::FN_LAST) begin
                                    n_field = r_field + 4'd1;
                                end
                                n_acc   = '0;
                                n_fd    = 3'd0;
                                n_neg   = 1'b0;
                                n_point = 1'b0;
                            end else if (r_field == gga_pkg::FN_NS
                                      || r_field == gga_pkg::FN_EW
                                      || r_field == gga_pkg::FN_ALT_U
                                      || r_field == gga_pkg::FN_GEO_U) begin
                                // only the first character of a unit field counts
                                if (r_fd == 3'd0) begin
                                    n_fd = 3'd1;
                                    if (r_field == gga_pkg::FN_NS && i_byte == gga_pkg::CH_S)
                                        n_units.neg_lat = 1'b1;
                                    if (r_field == gga_pkg::FN_EW && i_byte == gga_pkg::CH_W)
                                        n_units.neg_lon = 1'b1;
                                    if (r_field == gga_pkg::FN_ALT_U && i_byte == gga_pkg::CH_F)
                                        n_units.feet_alt = 1'b1;
                                    if (r_field == gga_pkg::FN_GEO_U && i_byte == gga_pkg::CH_F)
                                        n_units.feet_geo = 1'b1;
                                end
                            end else if (cur_slot != gga_pkg::NO_SLOT) begin
                                if (is_digit) begin
                                    if (r_point) begin
                                        if (r_fd < FD_MAX) begin
                                            n_acc = pushed;
                                            n_fd  = r_fd + 3'd1;
                                        end
                                    end else begin
                                        n_acc = pushed;
                                    end
                                end else if (i_byte == gga_pkg::CH_DOT) begin
                                    n_point = 1'b1;
                                end else if (i_byte == gga_pkg::CH_MINUS) begin
                                    n_neg = 1'b1;
                                end
                            end
                        end
                    end
                    PH_CHECK: begin
                        if (i_byte == gga_pkg::CH_CR) begin
                            op_fire       = 1'b1;
                            op_new.emit   = 1'b1;
                            op_new.status = (r_rx == r_xor) ? gga_pkg::ST_VALID
                                                            : gga_pkg::ST_CKSUM;
                        end else if (r_fd < 3'd2) begin
                            n_rx = {r_rx[3:0], gga_pkg::hex_value(i_byte)};
                            n_fd = r_fd + 3'd1;
                        end
                    end
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end

            // dollar and record emission both restart the parser
            if (op_fire && (op_new.clear || op_new.emit)) begin
                n_phase = (op_new.clear) ? PH_HEADER : PH_IDLE;
                n_hm    = 3'd0;
                n_field = 4'd0;
                n_xor   = 8'd0;
                n_rx    = 8'd0;
                n_acc   = '0;
                n_fd    = 3'd0;
                n_neg   = 1'b0;
                n_point = 1'b0;
                n_units = '0;
            end
            if (op_fire) begin
                n_op  = op_new;
                n_mag = r_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_hm     <= 3'd0;
            r_field  <= 4'd0;
            r_xor    <= 8'd0;
            r_acc    <= '0;
            r_fd     <= 3'd0;
            r_neg    <= 1'b0;
            r_point  <= 1'b0;
            r_rx     <= 8'd0;
            r_units  <= '0;
            r_op     <= '0;
        end else begin
            r_phase  <= n_phase;
            r_hm     <= n_hm;
            r_field  <= n_field;
            r_xor    <= n_xor;
            r_acc    <= n_acc;
            r_fd     <= n_fd;
            r_neg    <= n_neg;
            r_point  <= n_point;
            r_rx     <= n_rx;
            r_units  <= n_units;
            r_op     <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
    end

endmodule

// ===== src/gga_conv.sv =====
// ----------------------------------------------------------------------------
// gga_conv: field conversion and record store
// Pads the fraction, applies sign, maps quality and station, clamps and
// writes the record; hands the record out on an emit operation.
// ----------------------------------------------------------------------------
module gga_conv #(
    parameter int VALUE_BITS      = 36,
    parameter int FRACTION_DIGITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gga_pkg::t_op          i_op,
    input  logic [VALUE_BITS-1:0] i_mag,
    output logic                  o_take,
    input  logic                  i_e_en,
    output logic                  o_emit_valid,
    output gga_pkg::t_rec         o_rec,
    output gga_pkg::t_status      o_status,
    output gga_pkg::t_units       o_units
);

    localparam logic [VALUE_BITS-1:0] MAX_MAG = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [63:0] SCALE   = gga_pkg::POW10[FRACTION_DIGITS];
    localparam logic [63:0] STA_LIM = SCALE * 64'd1024;
    localparam int          STA_K   = 30 + $clog2(SCALE);
    localparam logic [63:0] STA_M   = ((64'd1 << STA_K) + SCALE - 64'd1) / SCALE;

    logic                          r_p1_valid;
    gga_pkg::t_op                  r_p1_ctl;
    logic signed [VALUE_BITS-1:0]  r_p1_val;
    gga_pkg::t_rec                 r_rec;

    logic                          p1_go;
    logic [2:0]                    pad_k;
    logic [VALUE_BITS+19:0]        pad_prod;
    logic [VALUE_BITS-1:0]         pad_mag;
    logic signed [VALUE_BITS-1:0]  val;
    logic signed [63:0]            v64;
    logic signed [63:0]            conv;
    logic signed [63:0]            clamped;
    logic [63:0]                   sta_prod;
    gga_pkg::t_rec                 rec_next;

    // stage one: fraction padding and sign
    assign pad_k    = 3'(FRACTION_DIGITS) - i_op.fd;
    assign pad_prod = (VALUE_BITS+20)'(i_mag) * (VALUE_BITS+20)'(gga_pkg::POW10[pad_k][19:0]);
    assign pad_mag  = (pad_prod > (VALUE_BITS+20)'(MAX_MAG)) ? MAX_MAG
                                                             : pad_prod[VALUE_BITS-1:0];
    assign val      = i_op.neg ? -$signed(pad_mag) : $signed(pad_mag);

    assign p1_go  = r_p1_valid && (!r_p1_ctl.emit || i_e_en);
    assign o_take = !r_p1_valid || p1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (o_take) begin
            r_p1_valid <= i_op.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_p1_ctl <= i_op;
            r_p1_val <= val;
        end
    end

    // stage two: slot specific mapping, clamp, record write
    assign v64      = 64'(r_p1_val);
    assign sta_prod = 64'(r_p1_val[29:0]) * STA_M;

    always_comb begin
        case (r_p1_ctl.slot)
            gga_pkg::SL_QUAL: begin
                if (v64 < $signed(SCALE) || v64 >= $signed(SCALE * 64'd5))
                    conv = 64'sd0;
                else if (v64 < $signed(SCALE * 64'd2))
                    conv = 64'sd1;
                else if (v64 < $signed(SCALE * 64'd3))
                    conv = 64'sd2;
                else if (v64 < $signed(SCALE * 64'd4))
                    conv = 64'sd3;
                else
                    conv = 64'sd4;
            end
            gga_pkg::SL_STA: begin
                if (v64 < 64'sd0)
                    conv = 64'sd0;
                else if (v64 >= $signed(STA_LIM))
                    conv = 64'sd1023;
                else
                    conv = $signed(64'(sta_prod >> STA_K));
            end
            default: conv = v64;
        endcase
    end

    always_comb begin
        clamped = conv;
        if (conv < gga_pkg::SLOT_LO[r_p1_ctl.slot])
            clamped = gga_pkg::SLOT_LO[r_p1_ctl.slot];
        else if (conv > gga_pkg::SLOT_HI[r_p1_ctl.slot])
            clamped = gga_pkg::SLOT_HI[r_p1_ctl.slot];
    end

    always_comb begin
        rec_next = r_rec;
        if (r_p1_ctl.commit) begin
            rec_next[r_p1_ctl.slot] = clamped[gga_pkg::SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec <= '0;
        end else if (p1_go) begin
            if (r_p1_ctl.clear || r_p1_ctl.emit)
                r_rec <= '0;
            else
                r_rec <= rec_next;
        end
    end

    assign o_emit_valid = r_p1_valid && r_p1_ctl.emit;
    assign o_rec        = rec_next;
    assign o_status     = r_p1_ctl.status;
    assign o_units      = r_p1_ctl.units;

endmodule

// ===== src/gga_feet.sv =====
// ----------------------------------------------------------------------------
// gga_feet: feet scaling lane
// Four register stages computing round(|v| * 3.28084) with sign restore and
// clamp; passes the value through when the unit is not feet.
// ----------------------------------------------------------------------------
module gga_feet (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [gga_pkg::SLOT_W-1:0] i_value,
    input  logic                              i_feet,
    output logic signed [gga_pkg::SLOT_W-1:0] o_value
);

    localparam logic [36:0] POS_MAX = 37'h0_7FFFFFFFF;
    localparam logic [36:0] NEG_MAX = 37'h0_800000000;

    logic [35:0] mag1;
    logic [63:0] q_prod;
    logic [33:0] rem_full;
    logic [63:0] u_prod;
    logic [36:0] res;

    // stage registers
    logic        r1_feet, r1_neg, r1_big;
    logic [33:0] r1_mag;
    logic [17:0] r1_q;
    logic [35:0] r1_orig;
    logic        r2_feet, r2_neg, r2_big;
    logic [16:0] r2_r;
    logic [17:0] r2_q;
    logic [35:0] r2_orig;
    logic        r3_feet, r3_neg, r3_big;
    logic [34:0] r3_t;
    logic [35:0] r3_qs;
    logic [35:0] r3_orig;
    logic        r4_feet, r4_neg, r4_big;
    logic [18:0] r4_u;
    logic [35:0] r4_qs;
    logic [35:0] r4_orig;

    assign mag1     = i_value[35] ? 36'(-i_value) : 36'(i_value);
    assign q_prod   = 64'(mag1[33:5]) * gga_pkg::FEET_M1;
    assign rem_full = r1_mag - 34'(r1_q) * 34'(gga_pkg::FEET_DEN);
    assign u_prod   = 64'(r3_t[34:5]) * gga_pkg::FEET_M2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_feet <= i_feet;
            r1_neg  <= i_value[35];
            r1_big  <= (mag1[35:34] != 2'b00);
            r1_mag  <= mag1[33:0];
            r1_q    <= 18'(q_prod >> gga_pkg::FEET_K1);
            r1_orig <= i_value;

            r2_feet <= r1_feet;
            r2_neg  <= r1_neg;
            r2_big  <= r1_big;
            r2_r    <= rem_full[16:0];
            r2_q    <= r1_q;
            r2_orig <= r1_orig;

            r3_feet <= r2_feet;
            r3_neg  <= r2_neg;
            r3_big  <= r2_big;
            r3_t    <= 35'(r2_r) * 35'(gga_pkg::FEET_NUM) + 35'(gga_pkg::FEET_HALF);
            r3_qs   <= 36'(r2_q) * 36'(gga_pkg::FEET_NUM);
            r3_orig <= r2_orig;

            r4_feet <= r3_feet;
            r4_neg  <= r3_neg;
            r4_big  <= r3_big;
            r4_u    <= 19'(u_prod >> gga_pkg::FEET_K2);
            r4_qs   <= r3_qs;
            r4_orig <= r3_orig;
        end
    end

    assign res = 37'(r4_qs) + 37'(r4_u);

    always_comb begin
        if (!r4_feet) begin
            o_value = r4_orig;
        end else if (r4_neg) begin
            if (r4_big || res > NEG_MAX)
                o_value = -36'sh800000000;
            else
                o_value = -$signed(res[35:0]);
        end else begin
            if (r4_big || res > POS_MAX)
                o_value = 36'sh7FFFFFFFF;
            else
                o_value = $signed(res[35:0]);
        end
    end

endmodule

// ===== src/nmea_gga_sentence_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser: GGA sentence to fixed point record
// Input channel takes one ASCII byte per word; output channel gives one
// record word per sentence line end, with a status code in tuser.
// Throughput: one byte per cycle, no dependence on content, while the output
//   is not stalled. Path: after the line-end byte is taken, the record word
//   passes through the parser op register, the padding stage, slot mapping
//   into the four stage feet scaling lanes and the output register. The four
//   feet lane stages are set by the two reciprocal multiplies of the divide
//   by 100000.
// Reset: all parser state, the record store and the pipeline valid bits
//   clear at once; the block waits for a dollar sign.
// Output stall: the record word holds in the output register and the emit
//   pipeline freezes. A record that reaches the padding stage waits there;
//   the next operation byte (comma, star, dollar or line end) then waits
//   in the op register, which backpressures the input channel. Bytes that
//   issue no operation keep flowing until that point.
// ----------------------------------------------------------------------------
module nmea_gga_sentence_parser #(
    parameter int VALUE_BITS      = 36,
    parameter int FRACTION_DIGITS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] text_byte
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] fix_time, [59:32] latitude, [88:60] longitude,
    // [91:89] fix_quality, [115:92] horiz_dilution, [151:116] altitude,
    // [187:152] geoid_separation, [214:188] correction_age,
    // [224:215] station_id, [231:225] zero
    output logic [231:0] o_m_tdata,
    output logic [1:0]   o_m_tuser    // [1:0] parse_status
);

    localparam int EDEPTH = 4;

    gga_pkg::t_op            op;
    logic [VALUE_BITS-1:0]   op_mag;
    logic                    take;
    logic                    e_en;
    logic                    emit_valid;
    gga_pkg::t_rec           rec;
    gga_pkg::t_status        status;
    gga_pkg::t_units         units;
    logic signed [35:0]      alt_val;
    logic signed [35:0]      geo_val;

    logic [EDEPTH-1:0]       r_ev;
    gga_pkg::t_rec           r_drec [EDEPTH];
    gga_pkg::t_status        r_dst  [EDEPTH];
    gga_pkg::t_units         r_dun  [EDEPTH];
    logic                    r_out_valid;
    logic [231:0]            r_out_data;
    gga_pkg::t_status        r_out_status;

    logic signed [35:0]      lat_v, lon_v;
    logic signed [35:0]      lat_s, lon_s;
    logic [231:0]            n_out_data;

    gga_parse #(
        .VALUE_BITS      (VALUE_BITS),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .o_ready (o_s_tready),
        .o_op    (op),
        .o_mag   (op_mag),
        .i_take  (take)
    );

    gga_conv #(
        .VALUE_BITS      (VALUE_BITS),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_mag        (op_mag),
        .o_take       (take),
        .i_e_en       (e_en),
        .o_emit_valid (emit_valid),
        .o_rec        (rec),
        .o_status     (status),
        .o_units      (units)
    );

    // emit pipeline moves as one whenever the output register can load
    assign e_en = !r_out_valid || i_m_tready;

    gga_feet u_feet_alt (
        .i_clk   (i_clk),
        .i_en    (e_en),
        .i_value ($signed(rec[gga_pkg::SL_ALT])),
        .i_feet  (units.feet_alt),
        .o_value (alt_val)
    );

    gga_feet u_feet_geo (
        .i_clk   (i_clk),
        .i_en    (e_en),
        .i_value ($signed(rec[gga_pkg::SL_GEO])),
        .i_feet  (units.feet_geo),
        .o_value (geo_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev        <= '0;
            r_out_valid <= 1'b0;
        end else if (e_en) begin
            r_ev        <= {r_ev[EDEPTH-2:0], emit_valid};
            r_out_valid <= r_ev[EDEPTH-1];
        end
    end

    // payload delay alongside the feet lanes
    always_ff @(posedge i_clk) begin
        if (e_en) begin
            r_drec[0] <= rec;
            r_dst[0]  <= status;
            r_dun[0]  <= units;
            for (int k = 1; k < EDEPTH; k++) begin
                r_drec[k] <= r_drec[k-1];
                r_dst[k]  <= r_dst[k-1];
                r_dun[k]  <= r_dun[k-1];
            end
            r_out_data   <= n_out_data;
            r_out_status <= r_dst[EDEPTH-1];
        end
    end

    // hemisphere sign is applied on the way out
    assign lat_v = $signed(r_drec[EDEPTH-1][gga_pkg::SL_LAT]);
    assign lon_v = $signed(r_drec[EDEPTH-1][gga_pkg::SL_LON]);
    assign lat_s = r_dun[EDEPTH-1].neg_lat ? -lat_v : lat_v;
    assign lon_s = r_dun[EDEPTH-1].neg_lon ? -lon_v : lon_v;

    assign n_out_data = {
        7'd0,
        r_drec[EDEPTH-1][gga_pkg::SL_STA][9:0],
        r_drec[EDEPTH-1][gga_pkg::SL_AGE][26:0],
        geo_val,
        alt_val,
        r_drec[EDEPTH-1][gga_pkg::SL_HDOP][23:0],
        r_drec[EDEPTH-1][gga_pkg::SL_QUAL][2:0],
        lon_s[28:0],
        lat_s[27:0],
        r_drec[EDEPTH-1][gga_pkg::SL_TIME][31:0]
    };

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_stall_freezes_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> $stable(r_ev))
        else $error("emit pipeline moved during output stall");

    a_unknown_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == gga_pkg::ST_UNKNOWN) |-> (o_m_tdata == '0))
        else $error("unknown sentence record carries data");

    a_quality_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[91:89] <= 3'd4))
        else $error("fix quality out of range");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser != 2'd3))
        else $error("undefined parse status");

endmodule
